// ===== rtl/core/ctw_pkg.sv =====
package ctw_pkg;

  localparam int WordW    = 64;
  localparam int NumWords = 4;
  localparam int RangeW   = 32;
  localparam int SpanW    = RangeW + 1;
  localparam int MantW    = 52;
  localparam int HalfW    = MantW / 2;
  localparam int ProdW    = HalfW + SpanW;

  localparam logic [WordW-1:0] MantMask   = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [WordW-1:0] OneExpBits = 64'h3FF0_0000_0000_0000;

  // Shift-and-XOR recurrence constants, one entry per state word
  localparam int ShiftA [NumWords] = '{31, 19, 24, 21};
  localparam int ShiftB [NumWords] = '{45, 30, 48, 39};
  localparam int KeepK  [NumWords] = '{1, 6, 9, 17};
  localparam int ShiftC [NumWords] = '{18, 28, 7, 8};

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_DRAW = 1'b1
  } kind_t;

  typedef struct packed {
    logic             load;
    logic             draw;
    logic [1:0]       index;
    logic [WordW-1:0] value;
  } bank_cmd_t;

  // One Tausworthe step with constant shift amounts
  function automatic logic [WordW-1:0] taus_step(input logic [WordW-1:0] z,
                                                 input int unsigned a,
                                                 input int unsigned b,
                                                 input int unsigned k,
                                                 input int unsigned c);
    logic [WordW-1:0] keep;
    keep = {WordW{1'b1}} << k;
    return (((z << a) ^ z) >> b) ^ ((z & keep) << c);
  endfunction

  // Lift a seed word that sits below 2^k by adding 2^k
  function automatic logic [WordW-1:0] raise_floor(input logic [WordW-1:0] v,
                                                   input int unsigned k);
    logic [WordW-1:0] floor_bit;
    floor_bit = {{(WordW-1){1'b0}}, 1'b1} << k;
    if ((v >> k) == '0) begin
      return v | floor_bit;
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/ctw_word_bank.sv =====
module ctw_word_bank (
  input  logic                             clk,
  input  ctw_pkg::bank_cmd_t               cmd,
  output logic [ctw_pkg::WordW-1:0]        mix
);
  import ctw_pkg::*;

  logic [WordW-1:0] words   [NumWords];
  logic [WordW-1:0] stepped [NumWords];

  // Advance every word and fold the new words together
  always_comb begin
    mix = '0;
    for (int i = 0; i < NumWords; i++) begin
      stepped[i] = taus_step(words[i], ShiftA[i], ShiftB[i], KeepK[i], ShiftC[i]);
      mix        = mix ^ stepped[i];
    end
  end

  // Commit a draw, or store one seeded word
  always_ff @(posedge clk) begin
    for (int i = 0; i < NumWords; i++) begin
      if (cmd.draw) begin
        words[i] <= stepped[i];
      end else if (cmd.load && cmd.index == 2'(i)) begin
        words[i] <= raise_floor(cmd.value, KeepK[i]);
      end
    end
  end

endmodule

// ===== rtl/core/ctw_range_pipe.sv =====
module ctw_range_pipe (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ctw_pkg::WordW-1:0]         mix,
  input  logic signed [ctw_pkg::RangeW-1:0] lo,
  input  logic signed [ctw_pkg::RangeW-1:0] hi,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ctw_pkg::WordW-1:0]         raw_bits,
  output logic [ctw_pkg::WordW-1:0]         unit_double_bits,
  output logic signed [ctw_pkg::RangeW-1:0] ranged_value
);
  import ctw_pkg::*;

  logic              s1_valid;
  logic [WordW-1:0]  s1_raw;
  logic [RangeW-1:0] s1_lo;
  logic [SpanW-1:0]  s1_span;

  logic              s2_valid;
  logic [WordW-1:0]  s2_raw;
  logic [RangeW-1:0] s2_lo;
  logic [ProdW-1:0]  s2_prod_hi;
  logic [ProdW-1:0]  s2_prod_lo;

  logic              s3_valid;
  logic [WordW-1:0]  s3_raw;
  logic [RangeW-1:0] s3_lo;
  logic [RangeW-1:0] s3_q;

  logic              en_out, en3, en2, en1;
  logic [SpanW-1:0]  span_in;
  logic [ProdW-1:0]  prod_hi, prod_lo;
  logic [ProdW:0]    q_sum;

  // Each stage moves when the one after it has room
  assign en_out   = !out_valid || out_ready;
  assign en3      = !s3_valid || en_out;
  assign en2      = !s2_valid || en3;
  assign en1      = !s1_valid || en2;
  assign in_ready = en1;

  // Span in 33 bits, wrapping
  assign span_in = {hi[RangeW-1], hi} - {lo[RangeW-1], lo} + SpanW'(1);

  // Split the mantissa into halves for two narrow products
  assign prod_hi = {{SpanW{1'b0}}, s1_raw[MantW-1:HalfW]} * {{HalfW{1'b0}}, s1_span};
  assign prod_lo = {{SpanW{1'b0}}, s1_raw[HalfW-1:0]} * {{HalfW{1'b0}}, s1_span};

  // Recombine the partial products and drop 52 fraction bits
  assign q_sum = {1'b0, s2_prod_hi} + (ProdW+1)'(s2_prod_lo >> HalfW);

  // Advance stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1)    s1_valid  <= in_valid;
      if (en2)    s2_valid  <= s1_valid;
      if (en3)    s3_valid  <= s2_valid;
      if (en_out) out_valid <= s3_valid;
    end
  end

  // Advance stage payloads
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_raw  <= mix;
      s1_lo   <= lo;
      s1_span <= span_in;
    end
    if (en2) begin
      s2_raw     <= s1_raw;
      s2_lo      <= s1_lo;
      s2_prod_hi <= prod_hi;
      s2_prod_lo <= prod_lo;
    end
    if (en3) begin
      s3_raw <= s2_raw;
      s3_lo  <= s2_lo;
      s3_q   <= q_sum[HalfW+RangeW-1:HalfW];
    end
    if (en_out) begin
      raw_bits         <= s3_raw;
      unit_double_bits <= (s3_raw & MantMask) | OneExpBits;
      ranged_value     <= s3_lo + s3_q;
    end
  end

  a_unit_exp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> unit_double_bits[WordW-1:MantW] == OneExpBits[WordW-1:MantW])
    else $error("unit double exponent is wrong");

  a_unit_mant: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> unit_double_bits[MantW-1:0] == raw_bits[MantW-1:0])
    else $error("unit double mantissa does not match raw bits");

  a_s3_hold: assert property (@(posedge clk) disable iff (rst)
    s3_valid && !en_out |=> s3_valid && $stable(s3_q))
    else $error("stalled stage lost its request");

endmodule

// ===== rtl/core/combined_tausworthe_prng_core.sv =====
// Combined four-word Tausworthe generator. A load request seeds one state word
// (raised by 2^k when below it) and gives no result; a draw request advances
// all four words and returns their XOR, the matching double in [1,2) and a
// ranged integer. One request is taken every clock unless a draw waits for the
// range pipe; a draw's result passes the state update, split 26x33 mantissa
// products, recombine and output register stages. A load is visible to any
// draw taken after it. All four words must be loaded before the first draw.
module combined_tausworthe_prng_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic                              kind,
  input  logic [1:0]                        word_index,
  input  logic [ctw_pkg::WordW-1:0]         word_value,
  input  logic signed [ctw_pkg::RangeW-1:0] range_low,
  input  logic signed [ctw_pkg::RangeW-1:0] range_high,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic [ctw_pkg::WordW-1:0]         raw_bits,
  output logic [ctw_pkg::WordW-1:0]         unit_double_bits,
  output logic signed [ctw_pkg::RangeW-1:0] ranged_value
);
  import ctw_pkg::*;

  logic                     s0_valid;
  kind_t                    s0_kind;
  logic [1:0]               s0_index;
  logic [WordW-1:0]         s0_value;
  logic signed [RangeW-1:0] s0_lo;
  logic signed [RangeW-1:0] s0_hi;

  logic                     pipe_ready;
  logic                     drain0;
  logic                     is_draw;
  bank_cmd_t                cmd;
  logic [WordW-1:0]         mix;

  // Loads retire here; draws wait for room in the range pipe
  assign is_draw   = s0_valid && s0_kind == KIND_DRAW;
  assign drain0    = s0_valid && (s0_kind == KIND_LOAD || pipe_ready);
  assign req_ready = !s0_valid || drain0;

  assign cmd.load  = s0_valid && s0_kind == KIND_LOAD;
  assign cmd.draw  = is_draw && pipe_ready;
  assign cmd.index = s0_index;
  assign cmd.value = s0_value;

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (req_ready) begin
      s0_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready) begin
      s0_kind  <= kind_t'(kind);
      s0_index <= word_index;
      s0_value <= word_value;
      s0_lo    <= range_low;
      s0_hi    <= range_high;
    end
  end

  ctw_word_bank u_bank (
    .clk (clk),
    .cmd (cmd),
    .mix (mix)
  );

  ctw_range_pipe u_range (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (is_draw),
    .in_ready         (pipe_ready),
    .mix              (mix),
    .lo               (s0_lo),
    .hi               (s0_hi),
    .out_valid        (res_valid),
    .out_ready        (res_ready),
    .raw_bits         (raw_bits),
    .unit_double_bits (unit_double_bits),
    .ranged_value     (ranged_value)
  );

endmodule

// ===== dv/combined_tausworthe_prng_core_tb.sv =====
`timescale 1ns / 100ps

module combined_tausworthe_prng_core_tb;

  localparam int RandRequests  = 450;
  localparam int StallLimit    = 5000;
  localparam int DrainCycles   = 20;
  localparam int MaxReports    = 10;
  localparam int DirectedCount = 23;

  localparam logic signed [31:0] IntMin = 32'sh8000_0000;
  localparam logic signed [31:0] IntMax = 32'sh7FFF_FFFF;
  localparam logic [63:0] MantBits = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [63:0] ExpOne   = 64'h3FF0_0000_0000_0000;

  // Per-word recurrence shifts and seed floor exponents
  localparam int UpdA [4] = '{31, 19, 24, 21};
  localparam int UpdB [4] = '{45, 30, 48, 39};
  localparam int UpdK [4] = '{1, 6, 9, 17};
  localparam int UpdC [4] = '{18, 28, 7, 8};

  typedef struct packed {
    logic [63:0]        raw;
    logic [63:0]        unit;
    logic signed [31:0] ranged;
  } draw_result_t;

  typedef struct packed {
    ctw_pkg::kind_t     kind;
    logic [1:0]         idx;
    logic [63:0]        value;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic               known;
    draw_result_t       typed;
  } stim_row_t;

  // Directed requests; typed results only where they follow from minimum seeds
  localparam stim_row_t DirectedRows [DirectedCount] = '{
    '{ctw_pkg::KIND_LOAD, 2'd0, 64'd0, 32'sd0, 32'sd0, 1'b0, '0},
    '{ctw_pkg::KIND_LOAD, 2'd1, 64'd0, 32'sd0, 32'sd0, 1'b0, '0},
    '{ctw_pkg::KIND_LOAD, 2'd2, 64'd0, 32'sd0, 32'sd0, 1'b0, '0},
    '{ctw_pkg::KIND_LOAD, 2'd3, 64'd0, 32'sd0, 32'sd0, 1'b0, '0},
    '{ctw_pkg::KIND_DRAW, 2'd0, 64'd0, 32'sd0, 32'sd0, 1'b1,
      '{64'h0000_0004_0209_0000, 64'h3FF0_0004_0209_0000, 32'sd0}},
    '{ctw_pkg::KIND_LOAD, 2'd0, 64'd0, IntMin, IntMax, 1'b0, '0},
    '{ctw_pkg::KIND_LOAD, 2'd1, 64'd0, IntMax, IntMin, 1'b0, '0},
    '{ctw_pkg::KIND_LOAD, 2'd2, 64'd0, IntMin, IntMin, 1'b0, '0},
    '{ctw_pkg::KIND_LOAD, 2'd3, 64'd0, IntMax, IntMax, 1'b0, '0},
    '{ctw_pkg::KIND_DRAW, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF, IntMin, IntMax, 1'b1,
      '{64'h0000_0004_0209_0000, 64'h3FF0_0004_0209_0000, 32'sh8000_4020}},
    '{ctw_pkg::KIND_LOAD, 2'd0, 64'd1, 32'sd0, 32'sd0, 1'b0, '0},
    '{ctw_pkg::KIND_LOAD, 2'd1, 64'd64, 32'sd0, 32'sd0, 1'b0, '0},
    '{ctw_pkg::KIND_LOAD, 2'd2, 64'd511, 32'sd0, 32'sd0, 1'b0, '0},
    '{ctw_pkg::KIND_LOAD, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 32'sd0, 32'sd0, 1'b0, '0},
    '{ctw_pkg::KIND_DRAW, 2'd0, 64'd0, IntMax, IntMax, 1'b0, '0},
    '{ctw_pkg::KIND_DRAW, 2'd1, 64'd0, IntMin, IntMin, 1'b0, '0},
    '{ctw_pkg::KIND_DRAW, 2'd2, 64'd0, IntMax, IntMin, 1'b0, '0},
    '{ctw_pkg::KIND_DRAW, 2'd0, 64'd0, 32'sd1, 32'sd0, 1'b0, '0},
    '{ctw_pkg::KIND_DRAW, 2'd0, 64'd0, 32'sd0, IntMax, 1'b0, '0},
    '{ctw_pkg::KIND_LOAD, 2'd0, 64'h8000_0000_0000_0000, 32'sd0, 32'sd0, 1'b0, '0},
    '{ctw_pkg::KIND_LOAD, 2'd3, 64'h0000_0000_0001_FFFF, 32'sd0, 32'sd0, 1'b0, '0},
    '{ctw_pkg::KIND_DRAW, 2'd0, 64'd0, IntMin, IntMax, 1'b0, '0},
    '{ctw_pkg::KIND_DRAW, 2'd0, 64'd0, -32'sd1000, 32'sd1000, 1'b0, '0}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_ready;
  logic                kind = 1'b0;
  logic [1:0]          word_index = '0;
  logic [63:0]         word_value = '0;
  logic signed [31:0]  range_low = '0;
  logic signed [31:0]  range_high = '0;
  logic                res_valid;
  logic                res_ready = 1'b0;
  logic [63:0]         raw_bits;
  logic [63:0]         unit_double_bits;
  logic signed [31:0]  ranged_value;

  logic [63:0]         gen_words [4];
  draw_result_t        pending_draws [$];
  int                  mismatch_count = 0;
  int                  loads_sent = 0;
  int                  draws_sent = 0;
  int                  results_checked = 0;
  int                  idle_cycles = 0;
  int                  res_stall = 0;
  logic [31:0]         cycle_count = '0;

  combined_tausworthe_prng_core uut (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_ready        (req_ready),
    .kind             (kind),
    .word_index       (word_index),
    .word_value       (word_value),
    .range_low        (range_low),
    .range_high       (range_high),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .raw_bits         (raw_bits),
    .unit_double_bits (unit_double_bits),
    .ranged_value     (ranged_value)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // One shift-and-XOR step of a single generator word
  function automatic logic [63:0] shift_xor_update(input logic [63:0] z, input int a,
                                                   input int b, input int k, input int c);
    logic [63:0] keep;
    keep = ~64'd0 << k;
    return (((z << a) ^ z) >> b) ^ ((z & keep) << c);
  endfunction

  // Mostly short gaps, a few long ones, none at all while quiet
  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Seed one word, lifting it past its floor when below
  task automatic seed_word(input logic [1:0] idx, input logic [63:0] value);
    logic [63:0] floor_val;
    floor_val = 64'd1 << UpdK[idx];
    if (value < floor_val) value = value + floor_val;
    gen_words[idx] = value;
  endtask

  // Advance all words and form the three draw outputs
  task automatic predict_draw(input logic signed [31:0] lo, input logic signed [31:0] hi,
                              output draw_result_t res);
    logic [63:0] mix;
    logic [63:0] mant;
    logic [32:0] span;
    logic [84:0] prod;
    mix = '0;
    for (int i = 0; i < 4; i++) begin
      gen_words[i] = shift_xor_update(gen_words[i], UpdA[i], UpdB[i], UpdK[i], UpdC[i]);
      mix ^= gen_words[i];
    end
    mant = mix & MantBits;
    span = {hi[31], hi} - {lo[31], lo} + 33'd1;
    prod = mant[51:0] * span;
    res.raw    = mix;
    res.unit   = mant | ExpOne;
    res.ranged = lo + prod[83:52];
  endtask

  task automatic note_mismatch(input string msg);
    if (mismatch_count < MaxReports) $display("MISMATCH: %s", msg);
    mismatch_count++;
  endtask

  // Present one request, hold it until taken, then update the prediction
  task automatic send_request(input stim_row_t row, input bit quiet);
    draw_result_t predicted;
    int gap;
    req_valid  <= 1'b1;
    kind       <= row.kind;
    word_index <= row.idx;
    word_value <= row.value;
    range_low  <= row.lo;
    range_high <= row.hi;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (row.kind == ctw_pkg::KIND_LOAD) begin
      seed_word(row.idx, row.value);
      loads_sent++;
    end else begin
      predict_draw(row.lo, row.hi, predicted);
      pending_draws.push_back(row.known ? row.typed : predicted);
      draws_sent++;
    end
    gap = pick_gap(quiet);
    if (gap > 0) begin
      // Drop valid and scramble the payload during the gap
      req_valid  <= 1'b0;
      kind       <= 1'($urandom_range(0, 1));
      word_index <= 2'($urandom_range(0, 3));
      word_value <= {$urandom, $urandom};
      range_low  <= $urandom;
      range_high <= $urandom;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Build one random request; all words are seeded by then
  task automatic random_row(output stim_row_t row);
    logic signed [31:0] a;
    logic signed [31:0] b;
    row = '0;
    a = $urandom;
    b = $urandom;
    if ($urandom_range(0, 99) < 20) begin
      row.kind = ctw_pkg::KIND_LOAD;
      row.idx  = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0: row.value = 64'($urandom_range(0, 1 << 18));
        1: row.value = (64'd1 << UpdK[row.idx]) - 64'($urandom_range(0, 1));
        default: row.value = {$urandom, $urandom};
      endcase
      row.lo = a;
      row.hi = b;
    end else begin
      row.kind  = ctw_pkg::KIND_DRAW;
      row.idx   = 2'($urandom_range(0, 3));
      row.value = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0: begin row.lo = a; row.hi = b; end
        1: begin row.lo = a; row.hi = a; end
        2: begin row.lo = IntMin; row.hi = IntMax; end
        3: begin row.lo = a; row.hi = a + $urandom_range(0, 15); end
        4: begin row.lo = $urandom_range(0, 1) ? IntMin : a; row.hi = IntMax; end
        default: begin
          row.lo = (a < b) ? a : b;
          row.hi = (a < b) ? b : a;
        end
      endcase
    end
  endtask

  // Main sequence: reset, directed table, random requests, drain
  initial begin
    stim_row_t row;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < DirectedCount; i++) send_request(DirectedRows[i], 1'b0);
    for (int n = 0; n < RandRequests; n++) begin
      random_row(row);
      send_request(row, ((n / 48) % 4) == 1);
    end
    req_valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    $display("Sent %0d loads and %0d draws, compared %0d results", loads_sent, draws_sent,
             results_checked);
    $display("Ranges: full, single value, reversed, zero span; stalls on both channels");
    if (mismatch_count == 0 && pending_draws.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Check each taken result against the oldest expectation and stall at random
  always @(posedge clk) begin
    draw_result_t exp_res;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        results_checked++;
        if (pending_draws.size() == 0) begin
          note_mismatch($sformatf("result with none expected raw=%h", raw_bits));
        end else begin
          exp_res = pending_draws.pop_front();
          if (raw_bits !== exp_res.raw)
            note_mismatch($sformatf("raw_bits exp %h got %h", exp_res.raw, raw_bits));
          if (unit_double_bits !== exp_res.unit)
            note_mismatch($sformatf("unit_double_bits exp %h got %h", exp_res.unit,
                                    unit_double_bits));
          if (ranged_value !== exp_res.ranged)
            note_mismatch($sformatf("ranged_value exp %0d got %0d", exp_res.ranged,
                                    ranged_value));
        end
      end
      if (res_stall > 0) begin
        res_stall--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
        res_stall = pick_gap(cycle_count[8:7] == 2'b01);
      end
    end
  end

  // Watchdog: end the run after too long without any handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst || (req_valid && req_ready) || (res_valid && res_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Watchdog: no handshake for %0d cycles", StallLimit);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule

// ===== files.f =====
rtl/core/ctw_pkg.sv
rtl/core/ctw_word_bank.sv
rtl/core/ctw_range_pipe.sv
rtl/core/combined_tausworthe_prng_core.sv
dv/combined_tausworthe_prng_core_tb.sv
